FILE: hdl/fpc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_pkg: shared types and constants
// Types and constants for the float-to-PCM24 output conditioner.
// ---------------------------------------------------------------------------
package fpc_pkg;

   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 20;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 64;
   localparam int GAIN_W  = 2 * MUL_B_W;
   localparam int VOL_W   = 17;
   localparam int WORD_W  = 24;
   localparam int CNT_W   = 16;

   localparam logic [VOL_W-1:0]   UNITY_VOLUME  = 17'd65536;
   // 8388607 * 65536
   localparam logic [GAIN_W-1:0]  GAIN_RESET    = 40'h7F_FFFF_0000;
   localparam logic [MUL_B_W-1:0] METER_SCALE   = 20'd1000;
   localparam logic [CNT_W-1:0]   COUNT_MAX     = 16'hFFFF;
   localparam logic [MUL_A_W-1:0] CLAMP_MANT    = 24'h80_0000;
   localparam logic [7:0]         EXP_ZERO      = 8'd0;
   localparam logic [7:0]         EXP_ALL_ONES  = 8'hFF;
   localparam logic [7:0]         EXP_UNITY     = 8'd127;
   localparam logic [7:0]         EXP_METER_SAT = 8'd150;
   localparam logic [7:0]         WORD_SH_BASE  = 8'd166;
   localparam logic [7:0]         CLAMP_SHIFT   = 8'd39;
   localparam logic [7:0]         SHIFT_LIMIT   = 8'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ADD,
      ST_WORD,
      ST_METER,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OPB_GAIN_LO,
      OPB_GAIN_HI,
      OPB_METER
   } opb_sel_type;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctl_type;

endpackage

FILE: hdl/fpc_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_mac: shared multiplier with accumulator
// One registered 24x20 unsigned multiplier; the accumulator either loads
// the product or adds it weighted by 2^20 to build a 24x40 product.
// ---------------------------------------------------------------------------
module fpc_mac (
   input  logic                         clock,
   input  fpc_pkg::mac_ctl_type         ctl,
   input  logic [fpc_pkg::MUL_A_W-1:0]  op_a,
   input  logic [fpc_pkg::MUL_B_W-1:0]  op_b,
   output logic [fpc_pkg::PROD_W-1:0]   prod,
   output logic [fpc_pkg::ACC_W-1:0]    acc
);

   logic [fpc_pkg::PROD_W-1:0] prod_ff;
   logic [fpc_pkg::PROD_W-1:0] prod_in;
   logic [fpc_pkg::ACC_W-1:0]  acc_ff;

   assign prod_in = fpc_pkg::PROD_W'(op_a) * fpc_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_load) begin
         acc_ff <= {{(fpc_pkg::ACC_W - fpc_pkg::PROD_W){1'b0}}, prod_ff};
      end else if (ctl.acc_add) begin
         acc_ff <= acc_ff + {prod_ff, {fpc_pkg::MUL_B_W{1'b0}}};
      end
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

FILE: hdl/float_to_pcm24_output_conditioner_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// float_to_pcm24_output_conditioner_top: float stereo frame to PCM24
// Converts two IEEE-754 single samples to signed 24-bit words with volume,
// keeps a peak meter (x1000) and a saturating NaN count.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ channel: one stereo frame per transfer (left/right sample bits).
//    req_stall is high while a frame is being worked on.
//  - rsp_ channel: left/right words plus the peak and NaN totals after the
//    frame. The result sits in an output register until taken.
//  - csr_: write volume (unsigned Q16, values above unity saturate to unity)
//    only while no frame is in flight.
//  - Each channel steps through MUL_LO, MUL_HI, ADD, WORD and METER on the
//    one shared 24x20 multiplier (two partial products of mantissa times
//    gain, one mantissa times 1000); rsp_valid rises when ST_DONE loads the
//    output register. A new frame is taken only once ST_DONE has been left.
//  - A stalled result holds; the next frame is accepted and processed
//    meanwhile, and its result waits until the output register frees up.
//  - Reset (synchronous): volume to unity, peak and NaN count to zero,
//    no result pending.
// ---------------------------------------------------------------------------
module float_to_pcm24_output_conditioner_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_left_sample_bits,
   input  logic [31:0]         req_right_sample_bits,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [23:0]  rsp_left_word,
   output logic signed [23:0]  rsp_right_word,
   output logic [15:0]         rsp_peak_x1000,
   output logic [15:0]         rsp_nan_total,
   input  logic                csr_wr_en,
   input  logic [16:0]         csr_wr_data
);

   fpc_pkg::state_type state_ff, state_in;
   logic ch_ff;

   logic [31:0] left_bits_ff, right_bits_ff;
   logic [fpc_pkg::GAIN_W-1:0] gain_ff;
   logic [fpc_pkg::CNT_W-1:0] peak_ff, nan_ff;
   logic [fpc_pkg::WORD_W-1:0] left_word_ff, right_word_ff;

   logic rsp_valid_ff;
   logic signed [23:0] rsp_left_word_ff, rsp_right_word_ff;
   logic [15:0] rsp_peak_ff, rsp_nan_ff;

   // strobes from the sequencer
   fpc_pkg::mac_ctl_type  mac_ctl;
   fpc_pkg::opb_sel_type  opb_sel;
   logic                  use_meter_a;
   logic                  req_take;
   logic                  word_we;
   logic                  meter_we;
   logic                  out_load;
   logic                  out_free;

   // channel decode
   logic [31:0] cur_bits;
   logic [7:0]  cur_exp;
   logic        cur_nan;
   logic        cur_clamp;
   logic [fpc_pkg::MUL_A_W-1:0] word_m, meter_m, op_a;
   logic [fpc_pkg::MUL_B_W-1:0] op_b;
   logic [fpc_pkg::PROD_W-1:0]  prod;
   logic [fpc_pkg::ACC_W-1:0]   acc;

   logic [7:0]  word_sh;
   logic [fpc_pkg::ACC_W-1:0]  acc_shifted;
   logic [fpc_pkg::WORD_W-1:0] mag, word_val;
   logic [7:0]  meter_sh;
   logic [33:0] meter_shifted;
   logic [fpc_pkg::CNT_W-1:0] meter_cand;

   logic [16:0] vol_sat;
   logic [fpc_pkg::GAIN_W-1:0] gain_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpc_pkg::ST_IDLE: begin
            if (req_valid) state_in = fpc_pkg::ST_MUL_LO;
         end
         fpc_pkg::ST_MUL_LO: state_in = fpc_pkg::ST_MUL_HI;
         fpc_pkg::ST_MUL_HI: state_in = fpc_pkg::ST_ADD;
         fpc_pkg::ST_ADD:    state_in = fpc_pkg::ST_WORD;
         fpc_pkg::ST_WORD:   state_in = fpc_pkg::ST_METER;
         fpc_pkg::ST_METER: begin
            state_in = ch_ff ? fpc_pkg::ST_DONE : fpc_pkg::ST_MUL_LO;
         end
         fpc_pkg::ST_DONE: begin
            if (out_free) state_in = fpc_pkg::ST_IDLE;
         end
         default: state_in = fpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mac_ctl     = '0;
      opb_sel     = fpc_pkg::OPB_GAIN_LO;
      use_meter_a = 1'b0;
      req_stall   = 1'b1;
      req_take    = 1'b0;
      word_we     = 1'b0;
      meter_we    = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         fpc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            req_take  = req_valid;
         end
         fpc_pkg::ST_MUL_LO: begin
            mac_ctl.mul_en = 1'b1;
         end
         fpc_pkg::ST_MUL_HI: begin
            mac_ctl.mul_en   = 1'b1;
            mac_ctl.acc_load = 1'b1;
            opb_sel          = fpc_pkg::OPB_GAIN_HI;
         end
         fpc_pkg::ST_ADD: begin
            mac_ctl.mul_en  = 1'b1;
            mac_ctl.acc_add = 1'b1;
            opb_sel         = fpc_pkg::OPB_METER;
            use_meter_a     = 1'b1;
         end
         fpc_pkg::ST_WORD:  word_we  = 1'b1;
         fpc_pkg::ST_METER: meter_we = 1'b1;
         fpc_pkg::ST_DONE:  out_load = out_free;
         default: ;
      endcase
   end

   // ---------------- channel decode ----------------
   assign cur_bits  = ch_ff ? right_bits_ff : left_bits_ff;
   assign cur_exp   = cur_bits[30:23];
   assign cur_nan   = (cur_exp == fpc_pkg::EXP_ALL_ONES) && (cur_bits[22:0] != 23'd0);
   assign cur_clamp = (cur_exp >= fpc_pkg::EXP_UNITY);

   // zero and denormal inputs multiply by zero; |x| >= 1 uses exactly 1.0
   always_comb begin
      if (cur_exp == fpc_pkg::EXP_ZERO) begin
         word_m  = '0;
         meter_m = '0;
      end else begin
         meter_m = {1'b1, cur_bits[22:0]};
         word_m  = cur_clamp ? fpc_pkg::CLAMP_MANT : {1'b1, cur_bits[22:0]};
      end
   end

   assign op_a = use_meter_a ? meter_m : word_m;

   always_comb begin
      case (opb_sel)
         fpc_pkg::OPB_GAIN_LO: op_b = gain_ff[fpc_pkg::MUL_B_W-1:0];
         fpc_pkg::OPB_GAIN_HI: op_b = gain_ff[fpc_pkg::GAIN_W-1:fpc_pkg::MUL_B_W];
         fpc_pkg::OPB_METER:   op_b = fpc_pkg::METER_SCALE;
         default:              op_b = '0;
      endcase
   end

   fpc_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .acc   (acc)
   );

   // word: acc = m * 8388607 * volume, scaled by 2^-(166 - exp)
   assign word_sh     = cur_clamp ? fpc_pkg::CLAMP_SHIFT : (fpc_pkg::WORD_SH_BASE - cur_exp);
   assign acc_shifted = acc >> word_sh[5:0];
   assign mag         = (word_sh >= fpc_pkg::SHIFT_LIMIT) ? '0
                                                          : acc_shifted[fpc_pkg::WORD_W-1:0];
   assign word_val    = cur_nan    ? '0 :
                        cur_bits[31] ? (~mag + 24'd1) : mag;

   // meter: prod = m * 1000, scaled by 2^-(150 - exp), saturating
   assign meter_sh      = fpc_pkg::EXP_METER_SAT - cur_exp;
   assign meter_shifted = prod[33:0] >> meter_sh[5:0];
   always_comb begin
      if (cur_exp >= fpc_pkg::EXP_METER_SAT) begin
         meter_cand = fpc_pkg::COUNT_MAX;
      end else if (meter_sh >= fpc_pkg::SHIFT_LIMIT) begin
         meter_cand = '0;
      end else if (meter_shifted[33:16] != 18'd0) begin
         meter_cand = fpc_pkg::COUNT_MAX;
      end else begin
         meter_cand = meter_shifted[15:0];
      end
   end

   // volume register kept as gain = volume * 8388607
   assign vol_sat = (csr_wr_data > fpc_pkg::UNITY_VOLUME) ? fpc_pkg::UNITY_VOLUME : csr_wr_data;
   assign gain_in = {vol_sat, 23'd0} - fpc_pkg::GAIN_W'(vol_sat);

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpc_pkg::ST_IDLE;
         ch_ff        <= 1'b0;
         gain_ff      <= fpc_pkg::GAIN_RESET;
         peak_ff      <= '0;
         nan_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) gain_ff <= gain_in;
         if (req_take) ch_ff <= 1'b0;
         else if (meter_we) ch_ff <= ~ch_ff;
         if (word_we && cur_nan && (nan_ff != fpc_pkg::COUNT_MAX)) begin
            nan_ff <= nan_ff + 16'd1;
         end
         if (meter_we && !cur_nan && (meter_cand > peak_ff)) begin
            peak_ff <= meter_cand;
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         left_bits_ff  <= req_left_sample_bits;
         right_bits_ff <= req_right_sample_bits;
      end
      if (word_we) begin
         if (ch_ff) right_word_ff <= word_val;
         else       left_word_ff  <= word_val;
      end
      if (out_load) begin
         rsp_left_word_ff  <= left_word_ff;
         rsp_right_word_ff <= right_word_ff;
         rsp_peak_ff       <= peak_ff;
         rsp_nan_ff        <= nan_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_word  = rsp_left_word_ff;
   assign rsp_right_word = rsp_right_word_ff;
   assign rsp_peak_x1000 = rsp_peak_ff;
   assign rsp_nan_total  = rsp_nan_ff;

`ifndef NO_ASSERTIONS
   a_take_starts_left: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == fpc_pkg::ST_MUL_LO && !ch_ff)
      else $error("frame transfer did not start on the left channel");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> peak_ff >= $past(peak_ff))
      else $error("peak meter decreased");

   a_nan_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (nan_ff == $past(nan_ff)) || (nan_ff == $past(nan_ff) + 16'd1))
      else $error("NaN count moved by more than one");

   a_word_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_word != 24'sh800000 && rsp_right_word != 24'sh800000)
      else $error("PCM word out of symmetric range");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: float_to_pcm24_output_conditioner_top
// Drives stereo float frames through the conditioner under random valid and
// stall gaps and checks every PCM word, peak level and NaN total against a
// bit-exact integer model of the conversion.
// ---------------------------------------------------------------------------
module testbench;

   localparam logic [63:0] PCM_FULL_SCALE = 64'd8388607;
   localparam logic [15:0] METER_MAX      = 16'hFFFF;
   localparam int          IDLE_LIMIT     = 5000;
   localparam int          HOLD_OFF       = 400;

   typedef struct packed {
      logic [23:0] left_word;
      logic [23:0] right_word;
      logic [15:0] peak;
      logic [15:0] nan_total;
   } pcm_frame_type;

   class conditioner_scoreboard_type;
      logic [16:0]   volume;
      logic [15:0]   peak_level;
      logic [15:0]   nan_count;
      pcm_frame_type frames_due[$];
      int            errors;

      function new();
         volume     = fpc_pkg::UNITY_VOLUME;
         peak_level = '0;
         nan_count  = '0;
         errors     = 0;
      endfunction

      function void set_volume(logic [16:0] v);
         volume = (v > fpc_pkg::UNITY_VOLUME) ? fpc_pkg::UNITY_VOLUME : v;
      endfunction

      function logic [15:0] meter_level(logic [31:0] b);
         logic [63:0] prod;
         int          sh;
         if (b[30:23] == fpc_pkg::EXP_ZERO) return '0;
         if (b[30:23] >= fpc_pkg::EXP_METER_SAT) return METER_MAX;
         sh = int'(fpc_pkg::EXP_METER_SAT) - int'(b[30:23]);
         if (sh >= int'(fpc_pkg::SHIFT_LIMIT)) return '0;
         prod = {40'd0, 1'b1, b[22:0]} * 64'(fpc_pkg::METER_SCALE);
         prod = prod >> sh;
         return (prod > 64'(METER_MAX)) ? METER_MAX : prod[15:0];
      endfunction

      function logic [23:0] pcm_word(logic [31:0] b);
         logic [63:0] mag;
         logic [63:0] prod;
         int          sh;
         if (b[30:23] == fpc_pkg::EXP_ZERO) begin
            mag = '0;
         end else if (b[30:23] >= fpc_pkg::EXP_UNITY) begin
            mag = (PCM_FULL_SCALE * 64'(volume)) >> 16;
         end else begin
            sh   = int'(fpc_pkg::WORD_SH_BASE) - int'(b[30:23]);
            prod = {40'd0, 1'b1, b[22:0]} * PCM_FULL_SCALE * 64'(volume);
            mag  = (sh >= int'(fpc_pkg::SHIFT_LIMIT)) ? 64'd0 : (prod >> sh);
         end
         if (b[31]) mag = -mag;
         return mag[23:0];
      endfunction

      // updates meter and NaN count for one channel, returns its word
      function logic [23:0] convert_channel(logic [31:0] b);
         logic [15:0] level;
         if (b[30:23] == fpc_pkg::EXP_ALL_ONES && b[22:0] != '0) begin
            if (nan_count != fpc_pkg::COUNT_MAX) nan_count = nan_count + 16'd1;
            return '0;
         end
         level = meter_level(b);
         if (level > peak_level) peak_level = level;
         return pcm_word(b);
      endfunction

      function void note_frame(logic [31:0] left_bits, logic [31:0] right_bits);
         pcm_frame_type f;
         f.left_word  = convert_channel(left_bits);
         f.right_word = convert_channel(right_bits);
         f.peak       = peak_level;
         f.nan_total  = nan_count;
         frames_due.push_back(f);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
      endtask

      task check_frame(pcm_frame_type got);
         pcm_frame_type want;
         if (frames_due.size() == 0) begin
            report("unexpected transfer", 32'(got.left_word), 32'd0);
            return;
         end
         want = frames_due.pop_front();
         if (got.left_word !== want.left_word)
            report("left_word", 32'(got.left_word), 32'(want.left_word));
         if (got.right_word !== want.right_word)
            report("right_word", 32'(got.right_word), 32'(want.right_word));
         if (got.peak !== want.peak)
            report("peak_x1000", 32'(got.peak), 32'(want.peak));
         if (got.nan_total !== want.nan_total)
            report("nan_total", 32'(got.nan_total), 32'(want.nan_total));
      endtask
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [31:0]         req_left_sample_bits = '0;
   logic [31:0]         req_right_sample_bits = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [23:0]  rsp_left_word;
   logic signed [23:0]  rsp_right_word;
   logic [15:0]         rsp_peak_x1000;
   logic [15:0]         rsp_nan_total;
   logic                csr_wr_en = 1'b0;
   logic [16:0]         csr_wr_data = '0;

   conditioner_scoreboard_type board;
   int tx_burst = 0;
   int rx_burst = 0;
   bit tx_no_idle = 1'b0;
   bit rx_no_idle = 1'b0;
   int rx_hold = 0;
   int idle_cycles = 0;

   float_to_pcm24_output_conditioner_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_left_sample_bits  (req_left_sample_bits),
      .req_right_sample_bits (req_right_sample_bits),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_left_word         (rsp_left_word),
      .rsp_right_word        (rsp_right_word),
      .rsp_peak_x1000        (rsp_peak_x1000),
      .rsp_nan_total         (rsp_nan_total),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial board = new();

   // mostly random waits, now and then a run with none
   function automatic int next_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // sample bits weighted toward the normal range up to exponent top_exp;
   // above 254 also infinities and raw bit patterns
   function automatic logic [31:0] random_sample(int top_exp);
      int         pick;
      int         ex;
      int         hi;
      logic       sgn;
      logic [22:0] mant;
      pick = $urandom_range(0, 99);
      sgn  = 1'($urandom);
      mant = 23'($urandom);
      hi   = (top_exp > 254) ? 254 : top_exp;
      if (pick < 5)
         return {sgn, fpc_pkg::EXP_ALL_ONES, 23'($urandom_range(1, 23'h7F_FFFF))};
      if (pick < 9)
         return {sgn, fpc_pkg::EXP_ZERO, ($urandom_range(0, 1) != 0) ? mant : 23'd0};
      if (pick < 14) begin
         ex = $urandom_range(1, 100);
      end else if (top_exp > 254 && pick < 26) begin
         return $urandom;
      end else if (top_exp > 254 && pick < 29) begin
         return {sgn, fpc_pkg::EXP_ALL_ONES, 23'd0};
      end else if (pick < 80) begin
         ex = $urandom_range(110, hi);
      end else begin
         ex = $urandom_range(101, hi);
      end
      return {sgn, 8'(ex), mant};
   endfunction

   task automatic send_frame(input logic [31:0] left_bits, input logic [31:0] right_bits);
      int gap;
      gap = tx_no_idle ? 0 : next_gap(tx_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_left_sample_bits  <= left_bits;
      req_right_sample_bits <= right_bits;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.frames_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_volume(input logic [16:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_volume(v);
   endtask

   task automatic run_phase(input int count, input int top_exp, input bit squeeze);
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == count / 4) rx_hold = HOLD_OFF;
         send_frame(random_sample(top_exp), random_sample(top_exp));
      end
      drain();
   endtask

   // receiver: random stall before each result, one long hold-off on request
   initial begin
      int n;
      forever begin
         if (rx_hold > 0) begin
            n       = rx_hold;
            rx_hold = 0;
         end else begin
            n = rx_no_idle ? 0 : next_gap(rx_burst);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // result check before input note: a result always belongs to an older frame
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_frame({rsp_left_word, rsp_right_word, rsp_peak_x1000, rsp_nan_total});
         if (req_valid && !req_stall)
            board.note_frame(req_left_sample_bits, req_right_sample_bits);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("float_to_pcm24_output_conditioner_top verification failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] opening[] = '{
         32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
         32'h0080_0000, 32'h3A80_0000, 32'h3F00_0000, 32'hBF00_0000,
         32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h3F80_0000, 32'hBF80_0000,
         32'h4000_0000, 32'hC280_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
         32'h7F80_0001, 32'h3F80_0000, 32'hFF80_0001, 32'hBF00_0000,
         32'h3DCC_CCCD, 32'h4282_8F5C};
      logic [31:0] big_values[] = '{
         32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h4B00_0000};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_volume(fpc_pkg::UNITY_VOLUME);

      // edge values, meter kept below saturation so later frames still move it
      for (int i = 0; i < opening.size(); i += 2)
         send_frame(opening[i], opening[i + 1]);
      drain();

      write_volume(17'd0);
      run_phase(150, 120, 1'b0);
      write_volume(17'd1);
      rx_no_idle = 1'b1;
      run_phase(150, 126, 1'b0);
      rx_no_idle = 1'b0;
      write_volume(17'h1_FFFF);   // above unity, saturates
      tx_no_idle = 1'b1;
      run_phase(200, 126, 1'b0);
      tx_no_idle = 1'b0;
      write_volume(17'd65535);
      run_phase(200, 132, 1'b0);
      write_volume(17'($urandom_range(0, 65536)));
      run_phase(300, 132, 1'b1);

      // infinities and huge values drive the meter to its ceiling
      write_volume(17'd32768);
      for (int i = 0; i < big_values.size(); i += 2)
         send_frame(big_values[i], big_values[i + 1]);
      run_phase(300, 255, 1'b0);
      write_volume(17'($urandom));
      run_phase(200, 255, 1'b0);

      // back-to-back frames with NaN on both channels
      tx_no_idle = 1'b1;
      rx_no_idle = 1'b1;
      for (int i = 0; i < 64; i++)
         send_frame({1'($urandom), fpc_pkg::EXP_ALL_ONES,
                     23'($urandom_range(1, 23'h7F_FFFF))},
                    {1'($urandom), fpc_pkg::EXP_ALL_ONES,
                     23'($urandom_range(1, 23'h7F_FFFF))});
      tx_no_idle = 1'b0;
      rx_no_idle = 1'b0;
      drain();
      write_volume(fpc_pkg::UNITY_VOLUME);
      run_phase(40, 255, 1'b0);

      if (board.errors == 0)
         $display("float_to_pcm24_output_conditioner_top verification clean");
      else
         $display("float_to_pcm24_output_conditioner_top verification failed");
      $finish;
   end

endmodule
